FILE: rtl/core/pcmmix_pkg.sv
package pcmmix_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int SAMPLE_DEPTH_DEF = 65536;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP  = 3'd2;
	localparam logic [2:0] MODE_VOL   = 3'd3;
	localparam logic [2:0] MODE_RATE  = 3'd4;
	localparam logic [2:0] MODE_TICK  = 3'd5;

	localparam logic [16:0] PHASE_WRAP = 17'd44100;
	localparam logic [15:0] GAIN_DEF   = 16'd10363;

	typedef struct packed {
		logic [15:0] start;
		logic [16:0] length;
		logic [15:0] position;
		logic        finished;
		logic [15:0] phase;
		logic [2:0]  rate_sel;
		logic [15:0] gain;
	} chan_t;

	localparam chan_t CHAN_RESET = '{start: 16'd0, length: 17'd0, position: 16'd0,
		finished: 1'b0, phase: 16'd0, rate_sel: 3'd0, gain: GAIN_DEF};

	localparam logic [16:0] RATE_STEP [5] = '{17'd3900, 17'd5200, 17'd7800, 17'd10400,
		17'd15600};

	localparam logic [7:0] VOL_MAP [16] = '{8'h6B, 8'h6F, 8'h71, 8'h74, 8'h76, 8'h79,
		8'h7B, 8'h7D, 8'h80, 8'h82, 8'h84, 8'h87, 8'h8A, 8'h8C, 8'h8F, 8'h91};

	localparam logic [15:0] GAIN_TABLE [97] = '{
		16'd5, 16'd6, 16'd6, 16'd7, 16'd7, 16'd8, 16'd9, 16'd10, 16'd10, 16'd11, 16'd12,
		16'd14, 16'd15, 16'd16, 16'd18, 16'd20, 16'd21, 16'd23, 16'd25, 16'd29, 16'd31,
		16'd33, 16'd37, 16'd41, 16'd46, 16'd50, 16'd54, 16'd60, 16'd66, 16'd72, 16'd80,
		16'd89, 16'd97, 16'd107, 16'd117, 16'd130, 16'd142, 16'd156, 16'd173, 16'd189,
		16'd205, 16'd226, 16'd246, 16'd267, 16'd308, 16'd328, 16'd369, 16'd410, 16'd431,
		16'd492, 16'd533, 16'd594, 16'd656, 16'd717, 16'd799, 16'd861, 16'd963, 16'd1045,
		16'd1147, 16'd1270, 16'd1393, 16'd1536, 16'd1700, 16'd1864, 16'd2048, 16'd2253,
		16'd2479, 16'd2724, 16'd2991, 16'd3298, 16'd3625, 16'd3994, 16'd4383, 16'd4834,
		16'd5325, 16'd5837, 16'd6431, 16'd7087, 16'd7783, 16'd8561, 16'd9442, 16'd10363,
		16'd11387, 16'd12555, 16'd13824, 16'd15217, 16'd16733, 16'd18371, 16'd20255,
		16'd22221, 16'd24454, 16'd26932, 16'd29696, 16'd32768, 16'd36127, 16'd39732,
		16'd43541};

	function automatic logic [15:0] gain_of(input logic [7:0] code);
		logic [15:0] g;
		g = 16'd0;
		if (code <= 8'd15) begin
			g = GAIN_TABLE[7'(VOL_MAP[code[3:0]] - 8'h40)];
		end else if (code >= 8'h40 && code <= 8'hA0) begin
			g = GAIN_TABLE[7'(code - 8'h40)];
		end
		return g;
	endfunction

	function automatic logic [2:0] rate_sel_of(input logic [7:0] idx);
		return (idx < 8'd5) ? idx[2:0] : 3'd2;
	endfunction

	function automatic logic [16:0] rate_step_of(input logic [2:0] sel);
		return (sel > 3'd4) ? RATE_STEP[2] : RATE_STEP[sel];
	endfunction

endpackage

FILE: rtl/core/pcmmix_req_if.sv
interface pcmmix_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [7:0]  channel;
	logic [15:0] address;
	logic [16:0] length;
	logic signed [15:0] sample_value;
	logic [7:0]  rate_index;
	logic [7:0]  volume_code;

	modport source (output valid, mode, channel, address, length, sample_value, rate_index,
		volume_code, input ready);
	modport sink (input valid, mode, channel, address, length, sample_value, rate_index,
		volume_code, output ready);
endinterface

FILE: rtl/core/pcmmix_rsp_if.sv
interface pcmmix_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [18:0] mix_sample;
	logic        status;

	modport source (output valid, mix_sample, status, input ready);
	modport sink (input valid, mix_sample, status, output ready);
endinterface

FILE: rtl/core/pcmmix_smem.sv
module pcmmix_smem import pcmmix_pkg::*; #(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
	localparam int AW = $clog2(SAMPLE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);
	logic [15:0] mem [SAMPLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/core/pcmmix_chmem.sv
module pcmmix_chmem import pcmmix_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  chan_t         wr_data,
	input  logic [CW-1:0] rd_addr,
	output chan_t         rd_data
);
	chan_t                   mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	chan_t                   rd_raw_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	// An entry never written reads as its reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : CHAN_RESET;
endmodule

FILE: rtl/core/pcmmix_scale.sv
module pcmmix_scale import pcmmix_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic               act,
	input  logic signed [15:0] sample,
	input  logic [15:0]        gain,
	output logic signed [15:0] value
);
	logic signed [32:0] prod_s1;
	logic               act_s1;
	logic signed [32:0] biased;
	logic signed [32:0] quot;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed({1'b0, gain}) * sample;
			act_s1  <= act;
		end
	end

	// gain*s*16/32768 truncated toward zero is gain*s/2048, then times four.
	always_comb begin
		biased = prod_s1 + (prod_s1[32] ? 33'sd2047 : 33'sd0);
		quot   = biased >>> 11;
		if (!act_s1) begin
			value = 16'sd0;
		end else if (quot > 33'sd8191) begin
			value = 16'sd32767;
		end else if (quot < -33'sd8191) begin
			value = -16'sd32767;
		end else begin
			value = {quot[13:0], 2'b00};
		end
	end
endmodule

FILE: rtl/core/pcm_sample_mixer_8ch_unit.sv
// Eight-channel sample player and mixer.
// The req_ch channel carries commands: write a sample word, start, stop,
// set volume or set rate of a channel, or tick one output sample. Every
// request yields exactly one response on rsp_ch with the mixed sample (zero
// except on a tick) and a status bit that flags a channel number out of range.
// One request is processed at a time. A sample write or an unused mode passes
// from acceptance through the execute state to the response register, a channel
// command in range also reads and writes back its channel state, and a tick visits
// every channel in turn: each channel takes a state read, a sample read with state
// write-back, a multiply and an add, all through one shared multiplier.
// The next request is accepted as soon as the previous one has moved into the
// response register, so a stalled receiver holds only that register; a second
// response waits in the last state until the register frees up.
// Reset empties the response register and returns every channel to its idle
// reset state (gain of volume code 15); sample memory is not cleared and must
// be written before it is played.
module pcm_sample_mixer_8ch_unit import pcmmix_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pcmmix_req_if.sink   req_ch,
	pcmmix_rsp_if.source rsp_ch
);
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int SW = (AW > 17) ? AW : 17;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_SMP  = 3'd4;
	localparam logic [2:0] S_ACC  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  mode_q;
	logic [7:0]  chan_q;
	logic [15:0] addr_q;
	logic [16:0] len_q;
	logic [15:0] val_q;
	logic [7:0]  rate_q;
	logic [7:0]  vol_q;
	logic [CW-1:0] cnt_q;
	logic        act_q;
	logic [15:0] gain_q;
	logic signed [18:0] acc_q;
	logic        stat_q;
	logic        out_v_q;
	logic signed [18:0] out_mix_q;
	logic        out_stat_q;

	logic          ch_ok;
	logic [CW-1:0] cmd_ch;
	logic [CW-1:0] ch_addr;
	chan_t         ch_rd;
	chan_t         ch_wr;
	logic          ch_we;
	logic          ch_act;
	logic [SW-1:0] s_sum;
	logic [16:0]   ph_next;
	logic [16:0]   pos_next;
	logic          wrapped;
	logic [15:0]   s_rd;
	logic signed [15:0] scaled;
	logic          out_free;
	logic          is_tick;

	assign ch_ok    = {1'b0, chan_q} < 9'(NUM_CHANNELS);
	assign cmd_ch   = CW'(chan_q);
	assign is_tick  = mode_q == MODE_TICK;
	assign ch_addr  = is_tick ? cnt_q : cmd_ch;
	assign out_free = !out_v_q || rsp_ch.ready;
	assign req_ch.ready = state_q == S_IDLE;

	pcmmix_chmem #(.NUM_CHANNELS(NUM_CHANNELS)) u_chmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ch_we),
		.wr_addr (ch_addr),
		.wr_data (ch_wr),
		.rd_addr (ch_addr),
		.rd_data (ch_rd)
	);

	assign s_sum = SW'(ch_rd.start) + SW'(ch_rd.position);

	pcmmix_smem #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_smem (
		.clk     (clk),
		.wr_en   (state_q == S_EXEC && mode_q == MODE_WRITE),
		.wr_addr (AW'(SW'(addr_q))),
		.wr_data (val_q),
		.rd_addr (s_sum[AW-1:0]),
		.rd_data (s_rd)
	);

	pcmmix_scale u_scale (
		.clk    (clk),
		.en     (state_q == S_SMP),
		.act    (act_q),
		.sample ($signed(s_rd)),
		.gain   (gain_q),
		.value  (scaled)
	);

	// Channel update: phase advance on a tick, or the command's edit.
	always_comb begin
		ch_act   = (ch_rd.length != 17'd0) && !ch_rd.finished;
		ph_next  = {1'b0, ch_rd.phase} + rate_step_of(ch_rd.rate_sel);
		wrapped  = ph_next >= PHASE_WRAP;
		pos_next = {1'b0, ch_rd.position} + 17'd1;
		ch_wr    = ch_rd;
		ch_we    = 1'b0;
		if (state_q == S_MOD) begin
			unique case (mode_q)
				MODE_TICK: begin
					ch_we = ch_act;
					if (wrapped) begin
						ch_wr.phase = 16'(ph_next - PHASE_WRAP);
						if (pos_next >= ch_rd.length || pos_next[16]) begin
							ch_wr.position = 16'd0;
							ch_wr.finished = 1'b1;
						end else begin
							ch_wr.position = pos_next[15:0];
						end
					end else begin
						ch_wr.phase = ph_next[15:0];
					end
				end
				MODE_START: begin
					ch_we = 1'b1;
					ch_wr = '{start: addr_q, length: len_q, position: 16'd0,
						finished: 1'b0, phase: 16'd0, rate_sel: rate_sel_of(rate_q),
						gain: gain_of(vol_q)};
				end
				MODE_STOP: begin
					ch_we = 1'b1;
					ch_wr.length   = 17'd0;
					ch_wr.position = 16'd0;
					ch_wr.finished = 1'b0;
					ch_wr.phase    = 16'd0;
				end
				MODE_VOL: begin
					ch_we = 1'b1;
					ch_wr.gain = gain_of(vol_q);
				end
				MODE_RATE: begin
					ch_we = 1'b1;
					ch_wr.rate_sel = rate_sel_of(rate_q);
				end
				default: begin
					ch_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			mode_q <= req_ch.mode;
			chan_q <= req_ch.channel;
			addr_q <= req_ch.address;
			len_q  <= req_ch.length;
			val_q  <= req_ch.sample_value;
			rate_q <= req_ch.rate_index;
			vol_q  <= req_ch.volume_code;
		end
		if (state_q == S_MOD) begin
			act_q  <= ch_act;
			gain_q <= ch_rd.gain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			acc_q      <= '0;
			stat_q     <= 1'b0;
			out_v_q    <= 1'b0;
			out_mix_q  <= '0;
			out_stat_q <= 1'b0;
		end else begin
			// The last state loads the response register itself.
			if (rsp_ch.ready && state_q != S_DONE) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_ch.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					cnt_q  <= '0;
					acc_q  <= '0;
					stat_q <= 1'b0;
					if (is_tick) begin
						state_q <= S_RD;
					end else if (mode_q >= MODE_START && mode_q <= MODE_RATE) begin
						stat_q  <= !ch_ok;
						state_q <= ch_ok ? S_RD : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= is_tick ? S_SMP : S_DONE;
				end
				S_SMP: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + 19'(scaled);
					if (cnt_q == CW'(NUM_CHANNELS - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_mix_q  <= acc_q;
						out_stat_q <= stat_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_ch.valid      = out_v_q;
	assign rsp_ch.mix_sample = out_mix_q;
	assign rsp_ch.status     = out_stat_q;
endmodule

FILE: rtl/core/pcmmix_chk.sv
module pcmmix_chk import pcmmix_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [2:0]        req_mode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic signed [18:0] rsp_mix,
	input logic              rsp_status
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_mix == 19'sd0)
		else $error("error response carries a mix value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");

	a_write_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid && req_mode == MODE_WRITE |-> ##3 rsp_valid)
		else $error("sample write response late");
endmodule

bind pcm_sample_mixer_8ch_unit pcmmix_chk u_pcmmix_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_ch.valid),
	.req_ready  (req_ch.ready),
	.req_mode   (req_ch.mode),
	.rsp_valid  (rsp_ch.valid),
	.rsp_ready  (rsp_ch.ready),
	.rsp_mix    (rsp_ch.mix_sample),
	.rsp_status (rsp_ch.status)
);
